@@ design/mpbf_pkg.sv @@
// Shared command codes, status codes, field widths and request types for the pipe pool.
`timescale 1ns / 1ps
`default_nettype none

package mpbf_pkg;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 2;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int FILL_W = 9;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE_R = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE_W = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EOF      = 3'd1;
    localparam logic [STAT_W-1:0] ST_WBLOCK   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BROKEN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTOPEN  = 3'd5;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mpbf_mem_req_t;

endpackage

`default_nettype wire

@@ design/mpbf_ram.sv @@
// Ring byte storage shared by all pipes, one access per beat, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpbf_ram
    import mpbf_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic                aclk,
    input  wire mpbf_mem_req_t       req,
    input  wire logic [ADDR_W-1:0]   addr,
    input  wire logic [BYTE_W-1:0]   wr_data,
    output logic      [BYTE_W-1:0]   rd_data
);

    logic [BYTE_W-1:0] ram_reg [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            ram_reg[addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= ram_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/mpbf_ctrl.sv @@
// Per-pipe pointers and open flags, command decode and the result register.
`timescale 1ns / 1ps
`default_nettype none

module mpbf_ctrl
    import mpbf_pkg::*;
#(
    parameter int PIPE_COUNT = 4,
    parameter int IDX_W      = 2,
    parameter int PTR_W      = 9,
    parameter int ADDR_W     = 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [ID_W-1:0]     pipe_id,
    output mpbf_mem_req_t            mem_req,
    output logic      [ADDR_W-1:0]   mem_addr,
    output logic      [STAT_W-1:0]   status,
    output logic      [ID_W-1:0]     pipe_id_out,
    output logic      [FILL_W-1:0]   fill_level,
    output logic                     rd_hit
);

    logic [PTR_W-1:0] wp_reg [PIPE_COUNT];
    logic [PTR_W-1:0] rp_reg [PIPE_COUNT];
    logic             ro_reg [PIPE_COUNT];
    logic             wo_reg [PIPE_COUNT];
    logic             alloc_reg [PIPE_COUNT];

    logic [STAT_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]   id_out_reg, id_out_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              rd_hit_reg;

    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  grant;
    logic              found;
    logic              id_ok;
    logic              is_open;
    logic [PTR_W-1:0]  fill;
    logic              full;
    logic              do_alloc, do_wr, do_rd, do_clr_r, do_clr_w, do_free;

    assign sel     = IDX_W'(pipe_id);
    assign id_ok   = int'(pipe_id) < PIPE_COUNT;
    assign is_open = id_ok && alloc_reg[sel];
    assign fill    = wp_reg[sel] - rp_reg[sel];
    assign full    = &fill;

    // Lowest-numbered free pipe wins an allocation.
    always_comb begin
        found = 1'b0;
        grant = '0;
        for (int k = 0; k < PIPE_COUNT; k++) begin
            if (!found && !alloc_reg[k]) begin
                found = 1'b1;
                grant = IDX_W'(k);
            end
        end
    end

    always_comb begin
        do_alloc    = 1'b0;
        do_wr       = 1'b0;
        do_rd       = 1'b0;
        do_clr_r    = 1'b0;
        do_clr_w    = 1'b0;
        do_free     = 1'b0;
        status_next = ST_NOTOPEN;
        id_out_next = pipe_id;
        fill_next   = '0;
        if (command == CMD_ALLOC) begin
            if (found) begin
                do_alloc    = 1'b1;
                status_next = ST_OK;
                id_out_next = ID_W'(grant);
            end else begin
                status_next = ST_NOFREE;
                id_out_next = '0;
            end
        end else if (is_open) begin
            case (command)
                CMD_WRITE: begin
                    fill_next = FILL_W'(fill);
                    if (!ro_reg[sel]) begin
                        status_next = ST_BROKEN;
                    end else if (full) begin
                        status_next = ST_WBLOCK;
                    end else begin
                        do_wr       = 1'b1;
                        status_next = ST_OK;
                        fill_next   = FILL_W'(fill + PTR_W'(1));
                    end
                end
                CMD_READ: begin
                    if (fill == '0) begin
                        status_next = wo_reg[sel] ? ST_WBLOCK : ST_EOF;
                    end else begin
                        do_rd       = 1'b1;
                        status_next = ST_OK;
                        fill_next   = FILL_W'(fill - PTR_W'(1));
                    end
                end
                CMD_CLOSE_R: begin
                    do_clr_r    = 1'b1;
                    do_free     = !wo_reg[sel];
                    status_next = ST_OK;
                    fill_next   = FILL_W'(fill);
                end
                CMD_CLOSE_W: begin
                    do_clr_w    = 1'b1;
                    do_free     = !ro_reg[sel];
                    status_next = ST_OK;
                    fill_next   = FILL_W'(fill);
                end
                default: begin
                    status_next = ST_NOTOPEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_COUNT; k++) begin
                wp_reg[k]    <= '0;
                rp_reg[k]    <= '0;
                ro_reg[k]    <= 1'b0;
                wo_reg[k]    <= 1'b0;
                alloc_reg[k] <= 1'b0;
            end
        end else if (accept) begin
            if (do_alloc) begin
                wp_reg[grant]    <= '0;
                rp_reg[grant]    <= '0;
                ro_reg[grant]    <= 1'b1;
                wo_reg[grant]    <= 1'b1;
                alloc_reg[grant] <= 1'b1;
            end
            if (do_wr) begin
                wp_reg[sel] <= wp_reg[sel] + PTR_W'(1);
            end
            if (do_rd) begin
                rp_reg[sel] <= rp_reg[sel] + PTR_W'(1);
            end
            if (do_clr_r) begin
                ro_reg[sel] <= 1'b0;
            end
            if (do_clr_w) begin
                wo_reg[sel] <= 1'b0;
            end
            if (do_free) begin
                alloc_reg[sel] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            id_out_reg <= id_out_next;
            fill_reg   <= fill_next;
            rd_hit_reg <= do_rd;
        end
    end

    assign mem_req.wr_en = accept && do_wr;
    assign mem_req.rd_en = accept && do_rd;
    assign mem_addr      = ADDR_W'({sel, do_wr ? wp_reg[sel] : rp_reg[sel]});

    assign status      = status_reg;
    assign pipe_id_out = id_out_reg;
    assign fill_level  = fill_reg;
    assign rd_hit      = rd_hit_reg;

endmodule

`default_nettype wire

@@ design/multi_pipe_byte_fifo_top.sv @@
// Top level of the byte pipe pool: handshakes, output register, controller and ring memory.
`timescale 1ns / 1ps
`default_nettype none

// A pool of PIPE_COUNT byte pipes, each a ring of RING_BYTES bytes (a power of two) that
// holds at most RING_BYTES-1 bytes. Every input beat carries one command and yields exactly
// one result beat, registered and presented in the cycle after acceptance. The block takes one
// beat per clock for as long as results are taken; the rate is set by the single-port ring
// memory, which serves one byte write or one byte read per beat. The ring memory is not
// cleared after reset, so the block is ready immediately; a byte is only ever read after it
// was written.
module multi_pipe_byte_fifo_top
    import mpbf_pkg::*;
#(
    parameter int PIPE_COUNT = 4,
    parameter int RING_BYTES = 512
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [CMD_W-1:0]    s_command,
    input  wire logic [ID_W-1:0]     s_pipe_id,
    input  wire logic [BYTE_W-1:0]   s_data_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [STAT_W-1:0]   m_status,
    output logic      [BYTE_W-1:0]   m_data_out,
    output logic      [ID_W-1:0]     m_pipe_id_out,
    output logic      [FILL_W-1:0]   m_fill_level
);

    localparam int IDX_W  = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int DEPTH  = PIPE_COUNT * RING_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              m_valid_reg;
    logic              accept;
    mpbf_mem_req_t     mem_req;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              rd_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    mpbf_ctrl #(
        .PIPE_COUNT (PIPE_COUNT),
        .IDX_W      (IDX_W),
        .PTR_W      (PTR_W),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .command     (s_command),
        .pipe_id     (s_pipe_id),
        .mem_req     (mem_req),
        .mem_addr    (mem_addr),
        .status      (m_status),
        .pipe_id_out (m_pipe_id_out),
        .fill_level  (m_fill_level),
        .rd_hit      (rd_hit)
    );

    mpbf_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .addr    (mem_addr),
        .wr_data (s_data_in),
        .rd_data (rd_data)
    );

    // The read byte lands in the memory's output register on the same edge as the result.
    assign m_data_out = rd_hit ? rd_data : '0;
    assign m_valid    = m_valid_reg;

endmodule

`default_nettype wire

@@ design/mpbf_checker.sv @@
// Port-level checks on the byte pipe pool and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module mpbf_checker
    import mpbf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [STAT_W-1:0]   m_status,
    input  wire logic [BYTE_W-1:0]   m_data_out,
    input  wire logic [ID_W-1:0]     m_pipe_id_out,
    input  wire logic [FILL_W-1:0]   m_fill_level
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_out)
            && $stable(m_pipe_id_out) && $stable(m_fill_level))
        else $error("result beat changed while stalled");

    // Every accepted command produces a result beat on the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted command produced no result beat");

    // A failed command carries no byte.
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_data_out == '0)
        else $error("data on a failed command");

    // A failed allocation names no pipe and no fill.
    a_nofree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NOFREE |-> m_pipe_id_out == '0 && m_fill_level == '0)
        else $error("failed allocation reported a pipe or fill");

    // Not-open and end-of-file always report an empty pipe.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NOTOPEN || m_status == ST_EOF) |-> m_fill_level == '0)
        else $error("nonzero fill with not-open or end-of-file");

endmodule

bind multi_pipe_byte_fifo_top mpbf_checker u_mpbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_data_out    (m_data_out),
    .m_pipe_id_out (m_pipe_id_out),
    .m_fill_level  (m_fill_level)
);

`default_nettype wire
